// ===== hw/rtl/imhe_pkg.sv =====
// Shared types and constants for the indexed min-heap block.
package imhe_pkg;

  localparam int VERT_W       = 8;
  localparam int DIST_W       = 31;
  localparam int POS_W        = 8;
  localparam int COUNT_W      = 9;
  localparam int VERTEX_COUNT = 256;
  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BITS_DEF = 31;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_BUILD   = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [VERT_W-1:0] vertex;
    logic [DIST_W-1:0] distance;
  } req_t;

  typedef struct packed {
    logic [VERT_W-1:0]  out_vertex;
    logic [DIST_W-1:0]  out_distance;
    logic [POS_W-1:0]   position;
    logic               was_empty;
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } rsp_t;

endpackage

// ===== hw/rtl/imhe_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module imhe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hw/rtl/indexed_min_heap_extract.sv =====
// Indexed binary min-heap of (vertex, distance) nodes with a vertex position map.
// Load, empty extract and a build of fewer than two nodes go straight to RESULT; query passes QRY.
// Extract: EXT_WR0, EXT_WR1, then SFT_RD and SFT_CMP per level L the new root sinks
// (L <= log2(CAPACITY) - 1), a last SFT_RD (and SFT_CMP unless at a leaf), SFT_FIN. Build: per
// internal node BLD_RD, BLD_LD and that sift. Input stalls until the result register loads.
// Synchronous reset empties the heap; node and position RAMs are not cleared.
module indexed_min_heap_extract #(
  parameter int CAPACITY = imhe_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = imhe_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  imhe_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output imhe_pkg::rsp_t rsp
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int SIZE_W = $clog2(CAPACITY + 1);
  localparam int CW     = IDX_W + 2;
  localparam int NODE_W = imhe_pkg::VERT_W + KEY_BITS;
  localparam int VA_W   = $clog2(imhe_pkg::VERTEX_COUNT);

  typedef enum logic [3:0] {
    IDLE, QRY, BLD_RD, BLD_LD, EXT_WR0, EXT_WR1, SFT_RD, SFT_CMP, SFT_FIN, RESULT
  } state_t;

  state_t state;

  logic [SIZE_W-1:0] size;
  logic [IDX_W-1:0]  at;
  logic [IDX_W-1:0]  bi;
  logic [NODE_W-1:0] cur;
  logic              moved;
  logic              building;

  logic [imhe_pkg::VERT_W-1:0]  res_v;
  logic [imhe_pkg::DIST_W-1:0]  res_d;
  logic [imhe_pkg::POS_W-1:0]   res_pos;
  logic                         res_empty;
  logic                         res_over;

  logic              node_we;
  logic [IDX_W-1:0]  node_waddr;
  logic [NODE_W-1:0] node_wdata;
  logic [IDX_W-1:0]  node_ra;
  logic [IDX_W-1:0]  node_rb;
  logic [NODE_W-1:0] node_rd_a;
  logic [NODE_W-1:0] node_rd_b;

  logic              pos_we;
  logic [VA_W-1:0]   pos_waddr;
  logic [IDX_W-1:0]  pos_wdata;
  logic [VA_W-1:0]   pos_ra;
  logic [IDX_W-1:0]  pos_rd;

  logic [CW-1:0]     lc;
  logic [CW-1:0]     rc;
  logic [CW-1:0]     size_cw;
  logic              lc_ok;
  logic              rc_ok;
  logic              full;
  logic [IDX_W-1:0]  last_idx;
  logic              left_less;
  logic              right_less;
  logic              swap;
  logic [NODE_W-1:0] lbest;
  logic [NODE_W-1:0] best_node;
  logic [IDX_W-1:0]  best_idx;
  logic [imhe_pkg::VERT_W-1:0] cur_v;
  logic              req_xfer;

  imhe_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_node_ram (
    .clk       (clk),
    .we        (node_we),
    .wr_addr   (node_waddr),
    .wr_data   (node_wdata),
    .rd_addr_a (node_ra),
    .rd_data_a (node_rd_a),
    .rd_addr_b (node_rb),
    .rd_data_b (node_rd_b)
  );

  imhe_ram #(.WIDTH(IDX_W), .DEPTH(imhe_pkg::VERTEX_COUNT)) u_pos_ram (
    .clk       (clk),
    .we        (pos_we),
    .wr_addr   (pos_waddr),
    .wr_data   (pos_wdata),
    .rd_addr_a (pos_ra),
    .rd_data_a (pos_rd),
    .rd_addr_b (pos_ra),
    .rd_data_b ()
  );

  assign req_stall = (state != IDLE);
  assign req_xfer  = req_valid && !req_stall;

  assign size_cw  = CW'(size);
  assign lc       = (CW'(at) << 1) + CW'(1);
  assign rc       = lc + CW'(1);
  assign lc_ok    = lc < size_cw;
  assign rc_ok    = rc < size_cw;
  assign full     = (size == SIZE_W'(CAPACITY));
  assign last_idx = IDX_W'(size - SIZE_W'(1));
  assign cur_v    = cur[NODE_W-1 -: imhe_pkg::VERT_W];

  // child selection: strict less, left checked first
  always_comb begin
    left_less  = node_rd_a[KEY_BITS-1:0] < cur[KEY_BITS-1:0];
    lbest      = left_less ? node_rd_a : cur;
    right_less = rc_ok && (node_rd_b[KEY_BITS-1:0] < lbest[KEY_BITS-1:0]);
    best_node  = right_less ? node_rd_b : lbest;
    best_idx   = right_less ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
    swap       = left_less || right_less;
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_ra    = '0;
    node_rb    = '0;
    pos_we     = 1'b0;
    pos_waddr  = '0;
    pos_wdata  = '0;
    pos_ra     = '0;
    case (state)
      IDLE: begin
        if (req_xfer) begin
          case (req.cmd)
            imhe_pkg::CMD_LOAD: begin
              if (!full) begin
                node_we    = 1'b1;
                node_waddr = IDX_W'(size);
                node_wdata = {req.vertex, KEY_BITS'(req.distance)};
                pos_we     = 1'b1;
                pos_waddr  = req.vertex;
                pos_wdata  = IDX_W'(size);
              end
            end
            imhe_pkg::CMD_EXTRACT: begin
              node_ra = '0;
              node_rb = last_idx;
            end
            imhe_pkg::CMD_QUERY: begin
              pos_ra = req.vertex;
            end
            default: ;
          endcase
        end
      end
      EXT_WR0: begin
        node_we    = 1'b1;
        node_waddr = '0;
        node_wdata = node_rd_b;
        pos_we     = 1'b1;
        pos_waddr  = node_rd_a[NODE_W-1 -: imhe_pkg::VERT_W];
        pos_wdata  = last_idx;
      end
      EXT_WR1: begin
        pos_we    = 1'b1;
        pos_waddr = cur_v;
        pos_wdata = '0;
      end
      BLD_RD: begin
        node_ra = bi;
      end
      SFT_RD: begin
        node_ra = lc[IDX_W-1:0];
        node_rb = rc[IDX_W-1:0];
      end
      SFT_CMP: begin
        if (swap) begin
          node_we    = 1'b1;
          node_waddr = at;
          node_wdata = best_node;
          pos_we     = 1'b1;
          pos_waddr  = best_node[NODE_W-1 -: imhe_pkg::VERT_W];
          pos_wdata  = at;
        end
      end
      SFT_FIN: begin
        if (moved) begin
          node_we    = 1'b1;
          node_waddr = at;
          node_wdata = cur;
          pos_we     = 1'b1;
          pos_waddr  = cur_v;
          pos_wdata  = at;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      size      <= '0;
      moved     <= 1'b0;
      building  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != RESULT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_xfer) begin
            res_v     <= '0;
            res_d     <= '0;
            res_pos   <= '0;
            res_empty <= 1'b0;
            res_over  <= 1'b0;
            building  <= 1'b0;
            case (req.cmd)
              imhe_pkg::CMD_LOAD: begin
                if (full) begin
                  res_over <= 1'b1;
                end else begin
                  size <= size + SIZE_W'(1);
                end
                state <= RESULT;
              end
              imhe_pkg::CMD_BUILD: begin
                if (size < SIZE_W'(2)) begin
                  state <= RESULT;
                end else begin
                  bi       <= IDX_W'((size >> 1) - SIZE_W'(1));
                  building <= 1'b1;
                  state    <= BLD_RD;
                end
              end
              imhe_pkg::CMD_EXTRACT: begin
                if (size == '0) begin
                  res_empty <= 1'b1;
                  state     <= RESULT;
                end else begin
                  state <= EXT_WR0;
                end
              end
              default: begin
                state <= QRY;
              end
            endcase
          end
        end
        QRY: begin
          res_pos <= imhe_pkg::POS_W'(pos_rd);
          state   <= RESULT;
        end
        EXT_WR0: begin
          res_v <= node_rd_a[NODE_W-1 -: imhe_pkg::VERT_W];
          res_d <= imhe_pkg::DIST_W'(node_rd_a[KEY_BITS-1:0]);
          size  <= size - SIZE_W'(1);
          cur   <= node_rd_b;
          at    <= '0;
          moved <= 1'b0;
          state <= EXT_WR1;
        end
        EXT_WR1: begin
          state <= SFT_RD;
        end
        BLD_RD: begin
          state <= BLD_LD;
        end
        BLD_LD: begin
          cur   <= node_rd_a;
          at    <= bi;
          moved <= 1'b0;
          state <= SFT_RD;
        end
        SFT_RD: begin
          state <= lc_ok ? SFT_CMP : SFT_FIN;
        end
        SFT_CMP: begin
          if (swap) begin
            at    <= best_idx;
            moved <= 1'b1;
            state <= SFT_RD;
          end else begin
            state <= SFT_FIN;
          end
        end
        SFT_FIN: begin
          if (building && (bi != '0)) begin
            bi    <= bi - IDX_W'(1);
            state <= BLD_RD;
          end else begin
            state <= RESULT;
          end
        end
        RESULT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.out_vertex   <= res_v;
            rsp.out_distance <= res_d;
            rsp.position     <= res_pos;
            rsp.was_empty    <= res_empty;
            rsp.overflow     <= res_over;
            rsp.count        <= imhe_pkg::COUNT_W'(size);
            state            <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_cmp_child_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == SFT_CMP) |-> (lc < size_cw))
    else $error("sift compare on a child outside the heap");

  a_extract_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == EXT_WR1) |-> (size == $past(size) - SIZE_W'(1)))
    else $error("extract did not shrink the heap by one");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (state == RESULT && res_over) |-> full)
    else $error("overflow flagged on a heap that is not full");

endmodule

// ===== bench/indexed_min_heap_extract_tb.sv =====
// Testbench for indexed_min_heap_extract: directed and random command streams checked against a heap model.
`timescale 1ns / 1ps

module indexed_min_heap_extract_tb;

  localparam int CAPACITY = imhe_pkg::CAPACITY_DEF;
  localparam int ITEM_TARGET = 1150;
  localparam int QUIET_FROM = 1000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int BIG_BATCH_ROOM = 400;

  class heap_model;
    logic [imhe_pkg::VERT_W-1:0] vert [CAPACITY];
    logic [imhe_pkg::DIST_W-1:0] node_key [CAPACITY];
    logic [imhe_pkg::POS_W-1:0]  pos [imhe_pkg::VERTEX_COUNT];
    int                          fill;
    imhe_pkg::rsp_t              expected_rsps [$];
    int                          mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void sink(int start);
      int                          at;
      int                          best;
      int                          lc;
      int                          rc;
      bit                          moving;
      logic [imhe_pkg::VERT_W-1:0] tv;
      logic [imhe_pkg::DIST_W-1:0] tk;
      at = start;
      moving = 1'b1;
      while (moving) begin
        best = at;
        lc = 2 * at + 1;
        rc = 2 * at + 2;
        if (lc < fill && node_key[lc] < node_key[best]) best = lc;
        if (rc < fill && node_key[rc] < node_key[best]) best = rc;
        if (best == at) begin
          moving = 1'b0;
        end else begin
          pos[vert[best]] = 8'(at);
          pos[vert[at]] = 8'(best);
          tv = vert[best];
          vert[best] = vert[at];
          vert[at] = tv;
          tk = node_key[best];
          node_key[best] = node_key[at];
          node_key[at] = tk;
          at = best;
        end
      end
    endfunction

    function void apply_cmd(imhe_pkg::req_t r);
      imhe_pkg::rsp_t              res;
      logic [imhe_pkg::VERT_W-1:0] top_v;
      logic [imhe_pkg::VERT_W-1:0] last_v;
      logic [imhe_pkg::DIST_W-1:0] top_k;
      int                          last;
      res = '0;
      case (r.cmd)
        imhe_pkg::CMD_LOAD: begin
          if (fill >= CAPACITY) begin
            res.overflow = 1'b1;
          end else begin
            vert[fill] = r.vertex;
            node_key[fill] = r.distance;
            pos[r.vertex] = 8'(fill);
            fill++;
          end
        end
        imhe_pkg::CMD_BUILD: begin
          for (int i = fill / 2 - 1; i >= 0; i--) sink(i);
        end
        imhe_pkg::CMD_EXTRACT: begin
          if (fill == 0) begin
            res.was_empty = 1'b1;
          end else begin
            top_v = vert[0];
            top_k = node_key[0];
            last = fill - 1;
            last_v = vert[last];
            vert[0] = last_v;
            node_key[0] = node_key[last];
            pos[top_v] = 8'(last);
            pos[last_v] = '0;
            fill = last;
            sink(0);
            res.out_vertex = top_v;
            res.out_distance = top_k;
          end
        end
        imhe_pkg::CMD_QUERY: begin
          res.position = pos[r.vertex];
        end
        default: ;
      endcase
      res.count = 9'(fill);
      expected_rsps.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_rsp(imhe_pkg::rsp_t got);
      imhe_pkg::rsp_t want;
      if (expected_rsps.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatches++;
        return;
      end
      want = expected_rsps.pop_front();
      check_field("out_vertex", 32'(want.out_vertex), 32'(got.out_vertex));
      check_field("out_distance", 32'(want.out_distance), 32'(got.out_distance));
      check_field("position", 32'(want.position), 32'(got.position));
      check_field("was_empty", 32'(want.was_empty), 32'(got.was_empty));
      check_field("overflow", 32'(want.overflow), 32'(got.overflow));
      check_field("count", 32'(want.count), 32'(got.count));
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  imhe_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  imhe_pkg::rsp_t rsp;

  heap_model heap = new();

  bit                          gaps_on = 1'b1;
  bit                          hold_request = 1'b0;
  int                          items_sent = 0;
  bit                          known [imhe_pkg::VERTEX_COUNT];
  logic [imhe_pkg::VERT_W-1:0] known_list [$];

  indexed_min_heap_extract dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) heap.compare_rsp(rsp);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(input imhe_pkg::req_t r);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    heap.apply_cmd(r);
    items_sent++;
  endtask

  task automatic issue(input imhe_pkg::cmd_t c, input logic [imhe_pkg::VERT_W-1:0] v,
                       input logic [imhe_pkg::DIST_W-1:0] d);
    imhe_pkg::req_t r;
    r.cmd = c;
    r.vertex = v;
    r.distance = d;
    if (c == imhe_pkg::CMD_LOAD && heap.fill < CAPACITY && !known[v]) begin
      known[v] = 1'b1;
      known_list.push_back(v);
    end
    send_req(r);
  endtask

  function automatic logic [imhe_pkg::DIST_W-1:0] pick_key(bit tie_heavy);
    if (tie_heavy) return imhe_pkg::DIST_W'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return imhe_pkg::DIST_W'($urandom_range(0, 15));
      default: return imhe_pkg::DIST_W'($urandom);
    endcase
  endfunction

  task automatic issue_query();
    if (known_list.size() == 0) begin
      issue(imhe_pkg::CMD_EXTRACT, 8'(0), '0);
    end else begin
      issue(imhe_pkg::CMD_QUERY, known_list[$urandom_range(0, known_list.size() - 1)],
            imhe_pkg::DIST_W'($urandom));
    end
  endtask

  task automatic issue_load(bit tie_heavy, bit dup_heavy);
    logic [imhe_pkg::VERT_W-1:0] v;
    v = dup_heavy ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    issue(imhe_pkg::CMD_LOAD, v, pick_key(tie_heavy));
  endtask

  // load a batch, usually order it with a build, then drain with extracts mixed with queries and stray commands
  task automatic run_batch(int nodes);
    bit tie_heavy;
    bit dup_heavy;
    int loads;
    tie_heavy = ($urandom_range(0, 3) == 0);
    dup_heavy = ($urandom_range(0, 3) == 0);
    loads = (nodes >= CAPACITY) ? nodes + 3 : nodes;
    for (int i = 0; i < loads; i++) begin
      case ($urandom_range(0, 19))
        0: issue_query();
        1: begin
          if (nodes < CAPACITY) begin
            issue(imhe_pkg::CMD_EXTRACT, 8'($urandom), imhe_pkg::DIST_W'($urandom));
          end
        end
        default: ;
      endcase
      issue_load(tie_heavy, dup_heavy);
    end
    if ($urandom_range(0, 7) != 0) begin
      issue(imhe_pkg::CMD_BUILD, 8'($urandom), imhe_pkg::DIST_W'($urandom));
    end
    while (heap.fill > 0) begin
      case ($urandom_range(0, 9))
        6, 7: issue_query();
        8: issue_load(tie_heavy, dup_heavy);
        9: issue(imhe_pkg::CMD_BUILD, 8'($urandom), imhe_pkg::DIST_W'($urandom));
        default: issue(imhe_pkg::CMD_EXTRACT, 8'($urandom), imhe_pkg::DIST_W'($urandom));
      endcase
    end
    issue(imhe_pkg::CMD_EXTRACT, 8'($urandom), imhe_pkg::DIST_W'($urandom));
  endtask

  initial begin
    int batch_no;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    issue(imhe_pkg::CMD_EXTRACT, 8'd0, '0);
    issue(imhe_pkg::CMD_BUILD, 8'd0, '0);
    issue(imhe_pkg::CMD_LOAD, 8'd255, '1);
    issue(imhe_pkg::CMD_BUILD, 8'd0, '0);
    issue(imhe_pkg::CMD_QUERY, 8'd255, '0);
    issue(imhe_pkg::CMD_LOAD, 8'd0, '0);
    issue(imhe_pkg::CMD_LOAD, 8'd7, 31'd5);
    issue(imhe_pkg::CMD_LOAD, 8'd7, 31'd5);
    issue(imhe_pkg::CMD_LOAD, 8'd128, 31'd5);
    issue(imhe_pkg::CMD_LOAD, 8'd1, 31'h4000_0000);
    issue(imhe_pkg::CMD_BUILD, 8'd0, '0);
    issue(imhe_pkg::CMD_QUERY, 8'd7, '0);
    issue(imhe_pkg::CMD_QUERY, 8'd0, '0);
    issue(imhe_pkg::CMD_QUERY, 8'd255, '0);
    repeat (6) issue(imhe_pkg::CMD_EXTRACT, 8'd0, '0);
    issue(imhe_pkg::CMD_QUERY, 8'd7, '0);

    batch_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) gaps_on = 1'b0;
      if (batch_no == 1) hold_request = 1'b1;
      if (batch_no == 0) begin
        run_batch(CAPACITY);
      end else if (items_sent + BIG_BATCH_ROOM < ITEM_TARGET
                   && $urandom_range(0, 9) == 0) begin
        run_batch($urandom_range(41, 120));
      end else begin
        run_batch($urandom_range(1, 40));
      end
      batch_no++;
    end
    req_valid <= 1'b0;

    while (heap.expected_rsps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (heap.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/imhe_pkg.sv
hw/rtl/imhe_ram.sv
hw/rtl/indexed_min_heap_extract.sv
bench/indexed_min_heap_extract_tb.sv
